@@ rtl/core/ffba_pkg.sv @@
package ffba_pkg;

    localparam int MAX_BLOCKS     = 64;
    localparam int IDX_W          = $clog2(MAX_BLOCKS);
    localparam int CNT_W          = IDX_W + 1;
    localparam int HEADER_BYTES   = 24;
    localparam int SENTINEL_BYTES = 8;
    localparam int ALIGN_BYTES    = 8;
    localparam int FIRST_OFFSET   = 40;
    localparam int SUM_W          = 18;
    localparam int POOL_LOG2_MIN  = 12;
    localparam int POOL_LOG2_MAX  = 16;
    localparam int POOL_LOG2_RST  = 16;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [IDX_W-1:0] data_raddr;
        logic [IDX_W-1:0] link_raddr;
        logic             data_we;
        logic [IDX_W-1:0] data_waddr;
        logic [15:0]      wr_start;
        logic [15:0]      wr_bytes;
        logic             link_we;
        logic [IDX_W-1:0] link_waddr;
        logic [IDX_W-1:0] link_wdata;
    } tbl_req_t;

    typedef struct packed {
        logic [15:0]      start;
        logic [15:0]      bytes;
        logic [IDX_W-1:0] link;
    } tbl_rsp_t;

    function automatic logic [SUM_W-1:0] align_up(input logic [SUM_W-1:0] x);
        return (x + SUM_W'(ALIGN_BYTES - 1)) & ~SUM_W'(ALIGN_BYTES - 1);
    endfunction

    function automatic logic [SUM_W-1:0] end_of(input logic [15:0] start,
                                                 input logic [15:0] bytes);
        return align_up(SUM_W'(start) + SUM_W'(HEADER_BYTES) + SUM_W'(bytes));
    endfunction

endpackage

@@ rtl/core/ffba_table.sv @@
module ffba_table (
    input  logic              aclk,
    input  ffba_pkg::tbl_req_t req,
    output ffba_pkg::tbl_rsp_t rsp
);

    logic [15:0]                start_mem [ffba_pkg::MAX_BLOCKS];
    logic [15:0]                bytes_mem [ffba_pkg::MAX_BLOCKS];
    logic [ffba_pkg::IDX_W-1:0] link_mem  [ffba_pkg::MAX_BLOCKS];

    logic [15:0]                start_rd_reg;
    logic [15:0]                bytes_rd_reg;
    logic [ffba_pkg::IDX_W-1:0] link_rd_reg;
    logic                       rd_sentinel_reg;

    always_ff @(posedge aclk) begin
        if (req.data_we) begin
            start_mem[req.data_waddr] <= req.wr_start;
            bytes_mem[req.data_waddr] <= req.wr_bytes;
        end
        start_rd_reg    <= start_mem[req.data_raddr];
        bytes_rd_reg    <= bytes_mem[req.data_raddr];
        rd_sentinel_reg <= (req.data_raddr == '0);
    end

    always_ff @(posedge aclk) begin
        if (req.link_we) begin
            link_mem[req.link_waddr] <= req.link_wdata;
        end
        link_rd_reg <= link_mem[req.link_raddr];
    end

    // the sentinel entry's start and size are fixed and never written; only its link is written
    assign rsp.start = rd_sentinel_reg ? 16'(ffba_pkg::FIRST_OFFSET) : start_rd_reg;
    assign rsp.bytes = rd_sentinel_reg ? 16'(ffba_pkg::SENTINEL_BYTES) : bytes_rd_reg;
    assign rsp.link  = link_rd_reg;

endmodule

@@ rtl/core/ffba_ctrl.sv @@
module ffba_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [4:0]         pool_size_log2,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_operation,
    input  logic [15:0]        s_request_bytes,
    input  logic [15:0]        s_free_offset,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [15:0]        m_data_offset,
    output logic [1:0]         m_status,
    output ffba_pkg::tbl_req_t req,
    input  ffba_pkg::tbl_rsp_t rsp
);

    localparam int W  = ffba_pkg::SUM_W;
    localparam int IW = ffba_pkg::IDX_W;
    localparam int CW = ffba_pkg::CNT_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_BUMP   = 3'd1;
    localparam logic [2:0] S_BUMP2  = 3'd2;
    localparam logic [2:0] S_WALK0  = 3'd3;
    localparam logic [2:0] S_WALK   = 3'd4;
    localparam logic [2:0] S_W1     = 3'd5;
    localparam logic [2:0] S_W2     = 3'd6;
    localparam logic [2:0] S_RESULT = 3'd7;

    logic [2:0]  state_reg, state_next;
    logic [ffba_pkg::MAX_BLOCKS-1:0] valid_reg, valid_next;
    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] last_reg, last_next;

    logic          op_reg, op_next;
    logic [15:0]   size_reg, size_next;
    logic [15:0]   offset_reg, offset_next;
    logic [IW-1:0] slot_reg, slot_next;
    logic [W-1:0]  cell_reg, cell_next;
    logic [W-1:0]  pos_reg, pos_next;
    logic [IW-1:0] prev_reg, prev_next;
    logic [IW-1:0] cur_reg, cur_next;
    logic [IW-1:0] steps_reg, steps_next;
    logic [IW-1:0] before_reg, before_next;
    logic [IW-1:0] after_reg, after_next;
    logic          bump_reg, bump_next;
    logic [15:0]   res_off_reg, res_off_next;
    logic [1:0]    res_st_reg, res_st_next;

    logic          m_valid_reg, m_valid_next;
    logic [15:0]   m_off_reg, m_off_next;
    logic [1:0]    m_st_reg, m_st_next;

    logic [IW-1:0] free_slot;
    logic [4:0]    lg;
    logic [W-1:0]  pool_end;
    logic [W-1:0]  new_end;
    logic [W-1:0]  cs;
    logic          fits;
    logic          hit;
    logic          walk_last;

    // lowest free entry above the sentinel
    always_comb begin
        free_slot = '0;
        for (int i = ffba_pkg::MAX_BLOCKS - 1; i >= 1; i--) begin
            if (!valid_reg[i]) free_slot = IW'(i);
        end
    end

    always_comb begin
        lg = pool_size_log2;
        if (lg < 5'(ffba_pkg::POOL_LOG2_MIN)) lg = 5'(ffba_pkg::POOL_LOG2_MIN);
        if (lg > 5'(ffba_pkg::POOL_LOG2_MAX)) lg = 5'(ffba_pkg::POOL_LOG2_MAX);
    end
    assign pool_end = W'(1) << lg;

    assign new_end   = ffba_pkg::align_up(pos_reg + W'(ffba_pkg::HEADER_BYTES) + W'(size_reg));
    assign cs        = W'(rsp.start);
    assign fits      = (cs >= pos_reg) && ((cs - pos_reg) >= cell_reg);
    assign hit       = ((W'(rsp.start) + W'(ffba_pkg::HEADER_BYTES)) == W'(offset_reg))
                       && (cur_reg != '0);
    assign walk_last = (cur_reg == last_reg) || (steps_reg == IW'(ffba_pkg::MAX_BLOCKS - 1));

    always_comb begin
        state_next   = state_reg;
        valid_next   = valid_reg;
        count_next   = count_reg;
        last_next    = last_reg;
        op_next      = op_reg;
        size_next    = size_reg;
        offset_next  = offset_reg;
        slot_next    = slot_reg;
        cell_next    = cell_reg;
        pos_next     = pos_reg;
        prev_next    = prev_reg;
        cur_next     = cur_reg;
        steps_next   = steps_reg;
        before_next  = before_reg;
        after_next   = after_reg;
        bump_next    = bump_reg;
        res_off_next = res_off_reg;
        res_st_next  = res_st_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_off_next   = m_off_reg;
        m_st_next    = m_st_reg;

        req            = '0;
        req.data_raddr = last_reg;
        req.wr_start   = pos_reg[15:0];
        req.wr_bytes   = size_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next      = s_operation;
                    size_next    = s_request_bytes;
                    offset_next  = s_free_offset;
                    slot_next    = free_slot;
                    cell_next    = ffba_pkg::align_up(W'(ffba_pkg::HEADER_BYTES)
                                                      + W'(s_request_bytes));
                    prev_next    = '0;
                    steps_next   = '0;
                    pos_next     = ffba_pkg::end_of(16'(ffba_pkg::FIRST_OFFSET),
                                                    16'(ffba_pkg::SENTINEL_BYTES));
                    res_off_next = '0;
                    if (s_operation == ffba_pkg::OP_ALLOC) begin
                        if (count_reg >= CW'(ffba_pkg::MAX_BLOCKS)) begin
                            res_st_next = ffba_pkg::ST_FULL;
                            state_next  = S_RESULT;
                        end else begin
                            state_next = S_BUMP;
                        end
                    end else if (last_reg == '0) begin
                        res_st_next = ffba_pkg::ST_NOT_FOUND;
                        state_next  = S_RESULT;
                    end else begin
                        req.link_raddr = '0;
                        state_next     = S_WALK0;
                    end
                end
            end
            S_BUMP: begin
                // end of the last block, read in the accept cycle
                pos_next   = ffba_pkg::end_of(rsp.start, rsp.bytes);
                state_next = S_BUMP2;
            end
            S_BUMP2: begin
                if (new_end < pool_end) begin
                    before_next = '0;
                    after_next  = last_reg;
                    bump_next   = 1'b1;
                    state_next  = S_W1;
                end else begin
                    bump_next = 1'b0;
                    pos_next  = ffba_pkg::end_of(16'(ffba_pkg::FIRST_OFFSET),
                                                 16'(ffba_pkg::SENTINEL_BYTES));
                    if (last_reg == '0) begin
                        res_st_next = ffba_pkg::ST_NO_SPACE;
                        state_next  = S_RESULT;
                    end else begin
                        req.link_raddr = '0;
                        state_next     = S_WALK0;
                    end
                end
            end
            S_WALK0: begin
                cur_next       = rsp.link;
                req.data_raddr = rsp.link;
                req.link_raddr = rsp.link;
                state_next     = S_WALK;
            end
            S_WALK: begin
                if (op_reg == ffba_pkg::OP_ALLOC && fits) begin
                    before_next = cur_reg;
                    after_next  = prev_reg;
                    state_next  = S_W1;
                end else if (op_reg == ffba_pkg::OP_FREE && hit) begin
                    req.link_we    = 1'b1;
                    req.link_waddr = prev_reg;
                    req.link_wdata = rsp.link;
                    if (cur_reg == last_reg) last_next = prev_reg;
                    valid_next[cur_reg] = 1'b0;
                    count_next  = count_reg - CW'(1);
                    res_st_next = ffba_pkg::ST_OK;
                    state_next  = S_RESULT;
                end else if (walk_last) begin
                    res_st_next = (op_reg == ffba_pkg::OP_ALLOC) ? ffba_pkg::ST_NO_SPACE
                                                                 : ffba_pkg::ST_NOT_FOUND;
                    state_next  = S_RESULT;
                end else begin
                    pos_next       = ffba_pkg::end_of(rsp.start, rsp.bytes);
                    prev_next      = cur_reg;
                    cur_next       = rsp.link;
                    steps_next     = steps_reg + IW'(1);
                    req.data_raddr = rsp.link;
                    req.link_raddr = rsp.link;
                end
            end
            S_W1: begin
                req.data_we    = 1'b1;
                req.data_waddr = slot_reg;
                req.link_we    = 1'b1;
                req.link_waddr = slot_reg;
                req.link_wdata = before_reg;
                state_next     = S_W2;
            end
            S_W2: begin
                req.link_we    = 1'b1;
                req.link_waddr = after_reg;
                req.link_wdata = slot_reg;
                valid_next[slot_reg] = 1'b1;
                count_next     = count_reg + CW'(1);
                if (bump_reg) last_next = slot_reg;
                res_off_next   = 16'(pos_reg + W'(ffba_pkg::HEADER_BYTES));
                res_st_next    = ffba_pkg::ST_OK;
                state_next     = S_RESULT;
            end
            S_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_off_next   = res_off_reg;
                    m_st_next    = res_st_reg;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            valid_reg   <= ffba_pkg::MAX_BLOCKS'(1);
            count_reg   <= CW'(1);
            last_reg    <= '0;
            bump_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            count_reg   <= count_next;
            last_reg    <= last_next;
            bump_reg    <= bump_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        size_reg    <= size_next;
        offset_reg  <= offset_next;
        slot_reg    <= slot_next;
        cell_reg    <= cell_next;
        pos_reg     <= pos_next;
        prev_reg    <= prev_next;
        cur_reg     <= cur_next;
        steps_reg   <= steps_next;
        before_reg  <= before_next;
        after_reg   <= after_next;
        res_off_reg <= res_off_next;
        res_st_reg  <= res_st_next;
        m_off_reg   <= m_off_next;
        m_st_reg    <= m_st_next;
    end

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_data_offset = m_off_reg;
    assign m_status      = m_st_reg;

`ifndef SYNTHESIS
    a_count_matches_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_reg) == 32'(count_reg))
        else $error("block count differs from valid entries");
    a_sentinel_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[0] && valid_reg[last_reg])
        else $error("sentinel or last block not valid");
    a_place_done: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_W2 |=> state_reg == S_RESULT && $past(count_reg) + CW'(1) == count_reg)
        else $error("placement did not complete");
    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> !req.data_we && !req.link_we)
        else $error("table written while idle");
`endif

endmodule

@@ rtl/core/first_fit_block_allocator_core.sv @@
// First-fit allocator over a power-of-two byte pool. Each request is an allocate (returns the
// new block's data offset) or a free (by data offset); one result comes back per request with
// a status. The block table sits in single-port-write memories with registered reads. An
// allocate that fits past the last block is placed there directly; otherwise the gap search
// walks the address-ordered list one block per cycle, as does a free. A new request is taken
// once the previous one has moved into the output register. The user must write
// pool_size_log2 through the cfg channel only while idle; the block itself does not enforce
// this. Values outside 12..16 are clamped.
module first_fit_block_allocator_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [15:0] s_request_bytes,
    input  logic [15:0] s_free_offset,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_data_offset,
    output logic [1:0]  m_status
);

    logic [4:0]         pool_log2_reg;
    ffba_pkg::tbl_req_t req;
    ffba_pkg::tbl_rsp_t rsp;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_log2_reg <= 5'(ffba_pkg::POOL_LOG2_RST);
        end else if (cfg_valid) begin
            pool_log2_reg <= cfg_data;
        end
    end

    ffba_table u_table (
        .aclk (aclk),
        .req  (req),
        .rsp  (rsp)
    );

    ffba_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .pool_size_log2  (pool_log2_reg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_request_bytes (s_request_bytes),
        .s_free_offset   (s_free_offset),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data_offset   (m_data_offset),
        .m_status        (m_status),
        .req             (req),
        .rsp             (rsp)
    );

endmodule
